// ----- src/hcmm_pkg.sv -----
`timescale 1ns / 1ps
package hcmm_pkg;

  localparam logic [2:0] ACT_READ  = 3'd0;
  localparam logic [2:0] ACT_WRITE = 3'd1;
  localparam logic [2:0] ACT_TICK  = 3'd2;
  localparam logic [2:0] ACT_BTN   = 3'd3;
  localparam logic [2:0] ACT_BOOT  = 3'd4;

  localparam logic [2:0] RGN_ROM0 = 3'd0;
  localparam logic [2:0] RGN_ROM1 = 3'd1;
  localparam logic [2:0] RGN_VRAM = 3'd2;
  localparam logic [2:0] RGN_SRAM = 3'd3;
  localparam logic [2:0] RGN_OAM  = 3'd4;
  localparam logic [2:0] RGN_DISP = 3'd5;

  // Selects which internal store supplies the read byte.
  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_FF,
    SRC_REG,
    SRC_BOOT,
    SRC_WRAM,
    SRC_HRAM
  } src_t;

  typedef struct packed {
    logic       valid;
    src_t       src;
    logic [7:0] reg_data;
    logic       ext;
    logic [2:0] region;
    logic       ext_wr;
    logic       ser_valid;
    logic [7:0] ser_byte;
  } stage_t;

  function automatic logic [7:0] audio_mask(input logic [4:0] idx);
    case (idx)
      5'd0:  audio_mask = 8'h80;
      5'd1:  audio_mask = 8'h3F;
      5'd4:  audio_mask = 8'hB8;
      5'd5:  audio_mask = 8'hFF;
      5'd6:  audio_mask = 8'h3F;
      5'd9:  audio_mask = 8'hB8;
      5'd10: audio_mask = 8'h7F;
      5'd11: audio_mask = 8'hFF;
      5'd12: audio_mask = 8'h9F;
      5'd14: audio_mask = 8'hB8;
      5'd15: audio_mask = 8'hFF;
      5'd16: audio_mask = 8'hFF;
      5'd19: audio_mask = 8'hBF;
      5'd22: audio_mask = 8'h70;
      default: audio_mask = 8'h00;
    endcase
  endfunction

endpackage

// ----- src/handheld_console_memory_map.sv -----
`timescale 1ns / 1ps
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle; s_tready holds while the result
// register is empty or being drained in the same cycle.
// Reset (rst, synchronous, active high) clears the I/O registers, releases
// all buttons and turns the boot overlay off; the RAMs are left unwritten.
module handheld_console_memory_map #(
  parameter int WORK_RAM_BYTES = 8192,
  parameter int BOOT_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata, low bit up: action[2:0], bus_address[18:3], bus_data[26:19],
  // button_index[29:27], button_level[30], zero pad [31].
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata, low bit up: read_data[7:0], external_access[8],
  // external_region[11:9], external_is_write[12], serial_valid[13],
  // serial_byte[21:14], zero pad [23:22].
  output logic [23:0] m_tdata
);
  localparam int WA = $clog2(WORK_RAM_BYTES);
  localparam int BA = $clog2(BOOT_BYTES);

  logic [2:0]  action;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic        fire, overlay_off, ser_valid;
  logic [7:0]  reg_data, ser_byte, boot_q, wram_q, hram_q, rd;
  hcmm_pkg::stage_t st, st_next;
  logic        is_rd, is_wr, routed;
  logic [2:0]  region;
  logic [15:0] addr_q, rd_addr;

  assign action = s_tdata[2:0];
  assign addr   = s_tdata[18:3];
  assign wdata  = s_tdata[26:19];

  // The result register is the only buffer; accept when it is free or drains.
  assign s_tready = !st.valid || m_tready;
  assign fire = s_tvalid && s_tready;
  assign is_rd = action == hcmm_pkg::ACT_READ;
  assign is_wr = action == hcmm_pkg::ACT_WRITE;

  // Outside regions: ROM banks, video RAM, cartridge RAM, OAM, display regs.
  always_comb begin
    routed = 1'b1;
    region = hcmm_pkg::RGN_ROM0;
    if (addr < 16'h4000) region = hcmm_pkg::RGN_ROM0;
    else if (addr < 16'h8000) region = hcmm_pkg::RGN_ROM1;
    else if (addr < 16'hA000) region = hcmm_pkg::RGN_VRAM;
    else if (addr < 16'hC000) region = hcmm_pkg::RGN_SRAM;
    else if (addr[15:8] == 8'hFE) region = hcmm_pkg::RGN_OAM;
    else if (addr >= 16'hFF40 && addr <= 16'hFF4B) region = hcmm_pkg::RGN_DISP;
    else routed = 1'b0;
  end

  hcmm_io u_io (
    .clk, .rst, .fire, .action, .addr, .wdata,
    .button_index(s_tdata[29:27]), .button_level(s_tdata[30]),
    .reg_data, .ser_valid, .ser_byte, .overlay_off
  );

  // While a result waits, the RAMs keep reading the address it was taken
  // from, so the registered read data stays put during a stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr_q <= '0;
    end else if (fire) begin
      addr_q <= addr;
    end
  end

  assign rd_addr = fire ? addr : addr_q;

  // RAM reads are registered, so their data lands with the result register.
  hcmm_ram #(.WIDTH(8), .DEPTH(BOOT_BYTES)) u_boot (
    .clk, .we(fire && action == hcmm_pkg::ACT_BOOT), .waddr(addr[BA-1:0]),
    .wdata, .raddr(rd_addr[BA-1:0]), .rdata(boot_q)
  );
  hcmm_ram #(.WIDTH(8), .DEPTH(WORK_RAM_BYTES)) u_wram (
    .clk, .we(fire && is_wr && !routed && addr < 16'hFE00), .waddr(addr[WA-1:0]),
    .wdata, .raddr(rd_addr[WA-1:0]), .rdata(wram_q)
  );
  hcmm_ram #(.WIDTH(8), .DEPTH(128)) u_hram (
    .clk, .we(fire && is_wr && addr[15:7] == 9'h1FF && addr != 16'hFFFF),
    .waddr(addr[6:0]), .wdata, .raddr(rd_addr[6:0]), .rdata(hram_q)
  );

  always_comb begin
    st_next = '0;
    st_next.valid = 1'b1;
    st_next.src = hcmm_pkg::SRC_NONE;
    if (is_rd) begin
      if (!overlay_off && addr < 16'h0100) st_next.src = hcmm_pkg::SRC_BOOT;
      else if (routed) begin
        st_next.src = hcmm_pkg::SRC_FF;
        st_next.ext = 1'b1;
        st_next.region = region;
      end else if (addr < 16'hFE00) st_next.src = hcmm_pkg::SRC_WRAM;
      else if (addr[15:7] == 9'h1FF && addr != 16'hFFFF) st_next.src = hcmm_pkg::SRC_HRAM;
      else begin
        st_next.src = hcmm_pkg::SRC_REG;
        st_next.reg_data = reg_data;
      end
    end else if (is_wr) begin
      if (routed) begin
        st_next.ext = 1'b1;
        st_next.region = region;
        st_next.ext_wr = 1'b1;
      end else begin
        st_next.ser_valid = ser_valid;
        st_next.ser_byte = ser_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.valid <= 1'b0;
    end else if (fire) begin
      st <= st_next;
    end else if (m_tready) begin
      st.valid <= 1'b0;
    end
  end

  always_comb begin
    case (st.src)
      hcmm_pkg::SRC_FF:   rd = 8'hFF;
      hcmm_pkg::SRC_REG:  rd = st.reg_data;
      hcmm_pkg::SRC_BOOT: rd = boot_q;
      hcmm_pkg::SRC_WRAM: rd = wram_q;
      hcmm_pkg::SRC_HRAM: rd = hram_q;
      default:            rd = 8'h00;
    endcase
  end

  assign m_tvalid = st.valid;
  assign m_tdata = {2'b00, st.ser_byte, st.ser_valid, st.ext_wr, st.region, st.ext, rd};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(st))
    else $error("pending result changed while stalled");
  a_ext: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !st.ext |-> st.region == 3'd0 && !st.ext_wr)
    else $error("region set without routing");
  a_ser: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st.ser_valid |-> !st.ext)
    else $error("serial emission on routed access");
endmodule

// ----- src/hcmm_ram.sv -----
`timescale 1ns / 1ps
module hcmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/hcmm_io.sv -----
`timescale 1ns / 1ps
// I/O register file; decodes one accepted request and updates registers.
module hcmm_io (
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  logic [2:0]   action,
  input  logic [15:0]  addr,
  input  logic [7:0]   wdata,
  input  logic [2:0]   button_index,
  input  logic         button_level,
  output logic [7:0]   reg_data,
  output logic         ser_valid,
  output logic [7:0]   ser_byte,
  output logic         overlay_off
);
  logic [7:0]  joypad, sdata, sctrl, tima, tma, tac, iflag, ienable;
  logic [7:0]  buttons;
  logic [15:0] cycle_count, div_base;
  logic [7:0]  audio [23];
  logic [7:0]  wave [16];
  logic [7:0]  joy_next, sctrl_next;
  logic [15:0] div_diff;
  logic        wr;

  assign wr = fire && action == hcmm_pkg::ACT_WRITE;
  assign div_diff = cycle_count - div_base;
  assign sctrl_next = 8'h7E | wdata;

  always_comb begin
    joy_next = 8'hCF | wdata;
    for (int k = 0; k < 4; k++) begin
      if (!joy_next[4] && !buttons[k]) joy_next[k] = 1'b0;
      if (!joy_next[5] && !buttons[k+4]) joy_next[k] = 1'b0;
    end
  end

  always_comb begin
    reg_data = 8'hFF;
    if (addr == 16'hFF00) reg_data = joypad;
    else if (addr == 16'hFF01) reg_data = sdata;
    else if (addr == 16'hFF02) reg_data = sctrl;
    else if (addr == 16'hFF04) reg_data = div_diff[15:8];
    else if (addr == 16'hFF05) reg_data = tima;
    else if (addr == 16'hFF06) reg_data = tma;
    else if (addr == 16'hFF07) reg_data = tac;
    else if (addr == 16'hFF0F) reg_data = iflag;
    else if (addr >= 16'hFF10 && addr <= 16'hFF26) reg_data = audio[5'(addr - 16'hFF10)];
    else if (addr[15:4] == 12'hFF3) reg_data = wave[addr[3:0]];
    else if (addr == 16'hFFFF) reg_data = ienable;
  end

  assign ser_valid = wr && addr == 16'hFF02 && sctrl_next[7];
  assign ser_byte  = ser_valid ? sdata : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      joypad <= '0; sdata <= '0; sctrl <= '0; tima <= '0; tma <= '0; tac <= '0;
      iflag <= '0; ienable <= '0; buttons <= '1; cycle_count <= '0; div_base <= '0;
      overlay_off <= 1'b1;
      for (int i = 0; i < 23; i++) audio[i] <= '0;
      for (int i = 0; i < 16; i++) wave[i] <= '0;
    end else if (fire) begin
      if (action == hcmm_pkg::ACT_TICK) cycle_count <= cycle_count + 16'd1;
      if (action == hcmm_pkg::ACT_BTN) buttons[button_index] <= button_level;
      if (action == hcmm_pkg::ACT_BOOT) overlay_off <= 1'b0;
      if (wr) begin
        if (addr == 16'hFF00) joypad <= joy_next;
        if (addr == 16'hFF01) sdata <= wdata;
        if (addr == 16'hFF02) begin
          sctrl <= {1'b0, sctrl_next[6:0]};
          if (sctrl_next[7]) sdata <= 8'h00;
        end
        if (addr == 16'hFF04) div_base <= cycle_count;
        if (addr == 16'hFF05) tima <= wdata;
        if (addr == 16'hFF06) tma <= wdata;
        if (addr == 16'hFF07) tac <= 8'hF8 | wdata;
        if (addr == 16'hFF0F) iflag <= 8'hE0 | wdata;
        if (addr >= 16'hFF10 && addr <= 16'hFF26)
          audio[5'(addr - 16'hFF10)] <= hcmm_pkg::audio_mask(5'(addr - 16'hFF10)) | wdata;
        if (addr[15:4] == 12'hFF3) wave[addr[3:0]] <= wdata;
        if (addr == 16'hFF50) overlay_off <= 1'b1;
        if (addr == 16'hFFFF) ienable <= wdata;
      end
    end
  end

  // The emitted byte always comes with a cleared data register next cycle.
  a_ser_clear: assert property (@(posedge clk) disable iff (rst)
    ser_valid && fire |=> sdata == 8'h00 && !sctrl[7])
    else $error("serial data not cleared after emission");
  a_tick: assert property (@(posedge clk) disable iff (rst)
    fire && action == hcmm_pkg::ACT_TICK |=> cycle_count == $past(cycle_count) + 16'd1)
    else $error("cycle count did not advance");
  a_boot: assert property (@(posedge clk) disable iff (rst)
    fire && action == hcmm_pkg::ACT_BOOT |=> !overlay_off)
    else $error("boot load did not enable overlay");
endmodule
